### src/nidacc_pkg.sv
// ----------------------------------------------------------------------------
// nidacc_pkg
// Shared types and constants for the nibble by int8 dot-product accumulator.
// ----------------------------------------------------------------------------
package nidacc_pkg;

    localparam int NUM_LANES = 8;
    localparam int BYTE_W    = 8;
    localparam int NIB_W     = 4;
    localparam int WORD_W    = NUM_LANES * BYTE_W;
    // One lane adds two products of a 4-bit unsigned and an 8-bit signed value.
    localparam int LANE_W    = 13;
    // Eight lane sums stay within 16 bits signed.
    localparam int CHUNK_W   = 16;
    localparam int SUM_W     = 32;

    typedef struct packed {
        logic valid;
        logic last;
    } nidacc_ctl_t;

endpackage

### src/nibble_int8_dot_accumulator_core.sv
// ----------------------------------------------------------------------------
// nibble_int8_dot_accumulator_core
// Eight lanes multiply weight nibbles by int8 activations; the chunk sum is
// added into a wrapping 32-bit accumulator that is emitted on the last item.
// ----------------------------------------------------------------------------
// The last item passes the lane and merge registers before m_valid rises.
// Throughput: one item per cycle; the lane stage, the merge stage and the
// accumulator each hold one item and advance independently.
// Only a result that waits at the output holds back a later last item.
// Reset (aresetn low, synchronous) clears the accumulator and all valid flags.
module nibble_int8_dot_accumulator_core
    import nidacc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [WORD_W-1:0]        s_weight_bytes,
    input  logic [WORD_W-1:0]        s_act_for_high,
    input  logic [WORD_W-1:0]        s_act_for_low,
    input  logic                     s_last,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [SUM_W-1:0]  m_dot_sum
);

    nidacc_ctl_t                        lane_ctl_reg;
    nidacc_ctl_t                        lane_ctl_next;
    logic [NUM_LANES-1:0][LANE_W-1:0]   lane_sums;
    logic                               merge_ready;
    nidacc_ctl_t                        merge_ctl;
    logic signed [CHUNK_W-1:0]          chunk_sum;
    logic                               acc_ready;
    logic                               acc_take;
    logic [SUM_W-1:0]                   sum_now;
    logic [SUM_W-1:0]                   acc_reg;
    logic [SUM_W-1:0]                   acc_next;
    logic [SUM_W-1:0]                   dot_reg;
    logic [SUM_W-1:0]                   dot_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;

    // Lane stage.
    assign s_ready = !lane_ctl_reg.valid || merge_ready;

    always_comb begin
        lane_ctl_next = lane_ctl_reg;
        if (s_ready) begin
            lane_ctl_next.valid = s_valid;
            lane_ctl_next.last  = s_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_ctl_reg <= '0;
        end else begin
            lane_ctl_reg <= lane_ctl_next;
        end
    end

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        nidacc_lane u_lane (
            .aclk        (aclk),
            .load        (s_ready),
            .weight_byte (s_weight_bytes[i*BYTE_W +: BYTE_W]),
            .act_high    (s_act_for_high[i*BYTE_W +: BYTE_W]),
            .act_low     (s_act_for_low[i*BYTE_W +: BYTE_W]),
            .lane_sum    (lane_sums[i])
        );
    end

    nidacc_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctl    (lane_ctl_reg),
        .lane_sums (lane_sums),
        .in_ready  (merge_ready),
        .out_ready (acc_ready),
        .out_ctl   (merge_ctl),
        .chunk_sum (chunk_sum)
    );

    // Accumulator stage. Only an item that produces a result needs a free output.
    assign acc_ready = !merge_ctl.last || !out_valid_reg || m_ready;
    assign acc_take  = merge_ctl.valid && acc_ready;
    assign sum_now   = acc_reg + {{(SUM_W-CHUNK_W){chunk_sum[CHUNK_W-1]}}, chunk_sum};

    always_comb begin
        acc_next       = acc_reg;
        dot_next       = dot_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (acc_take) begin
            if (merge_ctl.last) begin
                acc_next       = '0;
                dot_next       = sum_now;
                out_valid_next = 1'b1;
            end else begin
                acc_next = sum_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dot_reg <= dot_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_dot_sum = $signed(dot_reg);

endmodule

### src/nidacc_lane.sv
// ----------------------------------------------------------------------------
// nidacc_lane
// One lane: both nibbles of a weight byte times their activations, registered.
// ----------------------------------------------------------------------------
module nidacc_lane
    import nidacc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     load,
    input  logic [BYTE_W-1:0]        weight_byte,
    input  logic [BYTE_W-1:0]        act_high,
    input  logic [BYTE_W-1:0]        act_low,
    output logic signed [LANE_W-1:0] lane_sum
);

    logic signed [LANE_W-1:0] prod_high;
    logic signed [LANE_W-1:0] prod_low;
    logic signed [LANE_W-1:0] sum_reg;
    logic signed [LANE_W-1:0] sum_next;

    // Nibbles are unsigned, so a zero is put in front before the signed multiply.
    assign prod_high = $signed({{(LANE_W-NIB_W){1'b0}}, weight_byte[BYTE_W-1:NIB_W]})
                     * $signed({{(LANE_W-BYTE_W){act_high[BYTE_W-1]}}, act_high});
    assign prod_low  = $signed({{(LANE_W-NIB_W){1'b0}}, weight_byte[NIB_W-1:0]})
                     * $signed({{(LANE_W-BYTE_W){act_low[BYTE_W-1]}}, act_low});

    always_comb begin
        sum_next = sum_reg;
        if (load) begin
            sum_next = prod_high + prod_low;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
    end

    assign lane_sum = sum_reg;

endmodule

### src/nidacc_merge.sv
// ----------------------------------------------------------------------------
// nidacc_merge
// Adds the registered lane sums into one chunk sum, with its own pipeline slot.
// ----------------------------------------------------------------------------
module nidacc_merge
    import nidacc_pkg::*;
(
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  nidacc_ctl_t                           in_ctl,
    input  logic [NUM_LANES-1:0][LANE_W-1:0]      lane_sums,
    output logic                                  in_ready,
    input  logic                                  out_ready,
    output nidacc_ctl_t                           out_ctl,
    output logic signed [CHUNK_W-1:0]             chunk_sum
);

    nidacc_ctl_t              ctl_reg;
    nidacc_ctl_t              ctl_next;
    logic signed [CHUNK_W-1:0] chunk_reg;
    logic signed [CHUNK_W-1:0] chunk_next;
    logic signed [CHUNK_W-1:0] tree_sum;

    assign in_ready = !ctl_reg.valid || out_ready;

    always_comb begin
        tree_sum = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            tree_sum = tree_sum + {{(CHUNK_W-LANE_W){lane_sums[i][LANE_W-1]}}, lane_sums[i]};
        end
    end

    always_comb begin
        ctl_next   = ctl_reg;
        chunk_next = chunk_reg;
        if (in_ready) begin
            ctl_next   = in_ctl;
            chunk_next = tree_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        chunk_reg <= chunk_next;
    end

    assign out_ctl   = ctl_reg;
    assign chunk_sum = chunk_reg;

endmodule

### src/nidacc_checker.sv
// ----------------------------------------------------------------------------
// nidacc_checker
// Port-level checks for the dot-product accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module nidacc_checker
    import nidacc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic                     s_last,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic signed [SUM_W-1:0]  m_dot_sum
);

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_dot_sum))
        else $error("result changed or dropped while stalled");

    // The input side only stalls behind a result that waits at the output.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a waiting result");

    // Coming out of reset the block is empty and ready.
    a_reset_empty: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> s_ready && !m_valid)
        else $error("block not empty after reset");

    // After reset a result has to come through the lane and merge registers first.
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |=> !m_valid ##1 !m_valid)
        else $error("result appeared too early after reset");

    // An input item that waits keeps its valid and its last flag.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_last))
        else $error("input item changed or dropped while stalled");

endmodule

bind nibble_int8_dot_accumulator_core nidacc_checker u_nidacc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_last    (s_last),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_dot_sum (m_dot_sum)
);
